// File: hdl/adct_pkg.sv
`default_nettype none
package adct_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SLOPE,
		ST_MAG,
		ST_SCALE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_BCD_GO,
		ST_BCD_WAIT,
		ST_LOAD,
		ST_MINUS,
		ST_INT,
		ST_DOT,
		ST_FRAC,
		ST_CR,
		ST_LF
	} adct_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} adct_sts_t;

	localparam int SLOPE_K_W = 13;
	localparam logic [SLOPE_K_W-1:0] SLOPE_K = 13'd6600;
	localparam int OFFSET_W = 24;
	localparam logic [OFFSET_W-1:0] OFFSET_K = 24'd12592125;
	localparam int DIV_W = 16;
	localparam logic [DIV_W-1:0] DIVISOR_K = 16'd35217;
	localparam int MAX_CHARS = 9;
	localparam int ROOM_W = 4;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

endpackage
`default_nettype wire

// File: hdl/adc_temperature_to_ascii_line.sv
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata: adc_sample
// m       | out | m_tvalid/m_tready  | m_tdata: char_out, m_tlast: last_char
//
// Each sample passes through the bit-serial divider and then the serial BCD converter.
// Characters leave at most one per cycle while m_tready stays high; each suppressed
// leading zero leaves an idle slot in the character stream.
// arst_n clears the sequencer and the output valid; datapath registers are not reset.
// A stalled output holds the sequencer; a new sample is taken once the line-feed
// sits in the output register.
`default_nettype none
module adc_temperature_to_ascii_line #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRACTION_DIGITS = 2
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // adc_sample
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [7:0]                          m_tdata,  // char_out
	output logic                                     m_tlast
);
	import adct_pkg::*;

	localparam int SLOPE_W = SAMPLE_BITS + SLOPE_K_W;
	localparam int MAGNUM_W = (SLOPE_W > OFFSET_W) ? SLOPE_W : OFFSET_W;
	localparam int SCALE = 10 ** FRACTION_DIGITS;
	localparam int SCALE_W = $clog2(SCALE + 1);
	localparam int NUM_W = MAGNUM_W + SCALE_W;
	localparam int MAG_W = NUM_W - DIV_W + 1;
	localparam int DIG_N = (MAG_W * 30103) / 100000 + 1;
	localparam int POS_W = $clog2(DIG_N);
	localparam int ROOM_POS = MAX_CHARS - 3 - FRACTION_DIGITS;

	adct_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SLOPE_W-1:0]     slope_q;
	logic [MAGNUM_W-1:0]    magnum_q;
	logic [NUM_W-1:0]       num_q;
	logic                   neg_q;
	logic [ROOM_W-1:0]      room_q;
	logic [DIG_N*4-1:0]     dig_q;
	logic [POS_W-1:0]       pos_q;
	logic                   sat_q;
	logic                   started_q;

	logic                   m_tvalid_q;
	logic [7:0]             m_tdata_q;
	logic                   m_tlast_q;

	logic [MAG_W-1:0]       quotient;
	logic [DIG_N*4-1:0]     bcd;
	adct_sts_t              div_sts;
	adct_sts_t              bcd_sts;

	logic                   div_start;
	logic                   bcd_start;
	logic                   out_free;
	logic                   emit;
	logic [7:0]             emit_char;
	logic                   emit_last;
	logic                   dig_step;
	logic [3:0]             cur_dig;
	logic                   below_room;
	logic                   show;
	logic                   sat;
	logic [MAGNUM_W-1:0]    mag_slope;
	logic [MAGNUM_W-1:0]    mag_off;

	adct_div #(
		.NUM_W(NUM_W),
		.Q_W  (MAG_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num_q),
		.quotient(quotient),
		.sts     (div_sts)
	);

	adct_bcd #(
		.BIN_W(MAG_W),
		.DIG_N(DIG_N)
	) u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bcd_start),
		.bin   (quotient),
		.bcd   (bcd),
		.sts   (bcd_sts)
	);

	always_comb begin
		mag_slope  = MAGNUM_W'(slope_q);
		mag_off    = MAGNUM_W'(OFFSET_K);
		cur_dig    = dig_q[DIG_N*4-1 -: 4];
		below_room = (ROOM_W'(pos_q) - ROOM_W'(FRACTION_DIGITS)) < room_q;
		show       = sat_q ? below_room
			: (started_q || (cur_dig != 4'd0) || (pos_q == POS_W'(FRACTION_DIGITS)));
		sat = 1'b0;
		for (int p = FRACTION_DIGITS; p < DIG_N; p++) begin
			if ((ROOM_W'(p - FRACTION_DIGITS) >= room_q) && (bcd[p*4 +: 4] != 4'd0)) begin
				sat = 1'b1;
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		bcd_start = 1'b0;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		dig_step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SLOPE;
				end
			end
			ST_SLOPE: state_d = ST_MAG;
			ST_MAG:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					state_d = ST_BCD_GO;
				end
			end
			ST_BCD_GO: begin
				bcd_start = 1'b1;
				state_d   = ST_BCD_WAIT;
			end
			ST_BCD_WAIT: begin
				if (bcd_sts.done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_MINUS;
			ST_MINUS: begin
				if (!neg_q) begin
					state_d = ST_INT;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_char = CH_MINUS;
					state_d   = ST_INT;
				end
			end
			ST_INT: begin
				if (out_free) begin
					emit      = show;
					emit_char = sat_q ? CH_NINE : CH_ZERO + {4'd0, cur_dig};
					dig_step  = 1'b1;
					if (pos_q == POS_W'(FRACTION_DIGITS)) begin
						state_d = ST_DOT;
					end
				end
			end
			ST_DOT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = CH_DOT;
					state_d   = (FRACTION_DIGITS == 0) ? ST_CR : ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = CH_ZERO + {4'd0, cur_dig};
					dig_step  = 1'b1;
					if (pos_q == '0) begin
						state_d = ST_CR;
					end
				end
			end
			ST_CR: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = CH_CR;
					state_d   = ST_LF;
				end
			end
			ST_LF: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = CH_LF;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_SLOPE) begin
			slope_q <= SLOPE_W'(sample_q) * SLOPE_W'(SLOPE_K);
		end
		if (state_q == ST_MAG) begin
			neg_q    <= mag_slope > mag_off;
			magnum_q <= (mag_slope > mag_off) ? mag_slope - mag_off : mag_off - mag_slope;
			room_q   <= (mag_slope > mag_off) ? ROOM_W'(ROOM_POS - 1) : ROOM_W'(ROOM_POS);
		end
		if (state_q == ST_SCALE) begin
			num_q <= NUM_W'(magnum_q) * NUM_W'(SCALE);
		end
		if (state_q == ST_LOAD) begin
			dig_q     <= bcd;
			sat_q     <= sat;
			pos_q     <= POS_W'(DIG_N - 1);
			started_q <= 1'b0;
		end else if (dig_step) begin
			dig_q     <= {dig_q[DIG_N*4-5:0], 4'd0};
			pos_q     <= pos_q - 1'b1;
			started_q <= started_q | show;
		end
		if (emit) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_accept_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!div_sts.busy && !bcd_sts.busy))
		else $error("request accepted while a serial unit is busy");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata == CH_LF)))
		else $error("line end flag does not match line feed");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> ($past(div_sts.busy) && state_q == ST_DIV_WAIT))
		else $error("divider done outside its wait state");

	a_bcd_done: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_sts.done |-> ($past(bcd_sts.busy) && state_q == ST_BCD_WAIT))
		else $error("converter done outside its wait state");

endmodule
`default_nettype wire

// File: hdl/adct_div.sv
`default_nettype none
module adct_div #(
	parameter int NUM_W = 32,
	parameter int Q_W = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_W-1:0]    dividend,
	output logic      [Q_W-1:0]      quotient,
	output adct_pkg::adct_sts_t      sts
);
	import adct_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [DIV_W:0] DIV_CMP = {1'b0, DIVISOR_K};

	logic [NUM_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             qbit;
	logic [DIV_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		qbit  = trial >= DIV_CMP;
		diff  = trial - DIV_CMP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign quotient = quo_q[Q_W-1:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
`default_nettype wire

// File: hdl/adct_bcd.sv
`default_nettype none
module adct_bcd #(
	parameter int BIN_W = 17,
	parameter int DIG_N = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [BIN_W-1:0]     bin,
	output logic      [DIG_N*4-1:0]   bcd,
	output adct_pkg::adct_sts_t       sts
);
	import adct_pkg::*;

	localparam int CNT_W = $clog2(BIN_W + 1);

	logic [BIN_W-1:0]   bin_q;
	logic [DIG_N*4-1:0] bcd_q;
	logic [DIG_N*4-1:0] adj;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[DIG_N*4-2:0], bin_q[BIN_W-1]};
		end
	end

	assign bcd      = bcd_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import adct_pkg::*;

	localparam int SAMPLE_BITS = 12;
	localparam int FRACTION_DIGITS = 2;
	localparam int S_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int LINE_LATENCY = 120;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_SAMPLES = 63;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} line_char_t;

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;  // adc_sample
	logic           m_tvalid;
	logic           m_tready;
	logic [7:0]     m_tdata;  // char_out
	logic           m_tlast;

	line_char_t line_chars_q[$];
	int         error_count = 0;
	int         cycle_count = 0;
	bit         tx_idle_en = 1'b1;
	bit         rx_idle_en = 1'b1;
	int         hold_request = 0;
	int         hold_left = 0;
	int         stall_left = 0;

	adc_temperature_to_ascii_line #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic predict_line(input logic [S_W-1:0] raw);
		logic [63:0] sample;
		logic [63:0] scale;
		logic [63:0] slope;
		logic [63:0] mag_num;
		logic [63:0] mag;
		logic [63:0] ipart;
		logic [63:0] fpart;
		logic [63:0] limit;
		logic [3:0]  idig[20];
		logic [3:0]  fdig[8];
		bit          neg;
		int          nint;
		int          room;
		begin
			sample = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
			scale = 64'd1;
			for (int i = 0; i < FRACTION_DIGITS; i++)
				scale = scale * 64'd10;
			slope = 64'(SLOPE_K) * sample;
			if (slope > 64'(OFFSET_K)) begin
				neg = 1'b1;
				mag_num = slope - 64'(OFFSET_K);
			end else begin
				neg = 1'b0;
				mag_num = 64'(OFFSET_K) - slope;
			end
			mag = (mag_num * scale) / 64'(DIVISOR_K);
			ipart = mag / scale;
			fpart = mag % scale;
			room = MAX_CHARS - 3 - FRACTION_DIGITS - (neg ? 1 : 0);
			if (room < 1)
				room = 1;
			limit = 64'd1;
			for (int i = 0; i < room; i++)
				limit = limit * 64'd10;
			limit = limit - 64'd1;
			if (ipart > limit)
				ipart = limit;
			nint = 0;
			do begin
				idig[nint] = 4'(ipart % 64'd10);
				nint++;
				ipart = ipart / 64'd10;
			end while (ipart != 64'd0 && nint < 20);
			for (int i = FRACTION_DIGITS - 1; i >= 0; i--) begin
				fdig[i] = 4'(fpart % 64'd10);
				fpart = fpart / 64'd10;
			end
			if (neg)
				line_chars_q.push_back('{CH_MINUS, 1'b0});
			for (int i = nint - 1; i >= 0; i--)
				line_chars_q.push_back('{CH_ZERO + 8'(idig[i]), 1'b0});
			line_chars_q.push_back('{CH_DOT, 1'b0});
			for (int i = 0; i < FRACTION_DIGITS; i++)
				line_chars_q.push_back('{CH_ZERO + 8'(fdig[i]), 1'b0});
			line_chars_q.push_back('{CH_CR, 1'b0});
			line_chars_q.push_back('{CH_LF, 1'b1});
		end
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
		int gap;
		begin
			gap = tx_idle_en ? pick_gap() : 0;
			@(negedge clk);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= S_W'(sample);
			do
				@(posedge clk);
			while (!s_tready);
			predict_line(S_W'(sample));
		end
	endtask

	task automatic wait_lines_done();
		begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (line_chars_q.size() != 0)
				@(posedge clk);
			repeat (LINE_LATENCY) @(posedge clk);
		end
	endtask

	task automatic test_extremes();
		begin
			send_sample(12'd0);
			send_sample(12'd4095);
			send_sample(12'h555);
			send_sample(12'hAAA);
			wait_lines_done();
		end
	endtask

	task automatic test_sign_boundary();
		begin
			send_sample(12'd1902);
			send_sample(12'd1903);
			send_sample(12'd1907);
			send_sample(12'd1908);
			send_sample(12'd1913);
			send_sample(12'd1914);
			wait_lines_done();
		end
	endtask

	task automatic test_digit_count();
		begin
			send_sample(12'd1374);
			send_sample(12'd1375);
			send_sample(12'd1854);
			send_sample(12'd1855);
			send_sample(12'd1961);
			send_sample(12'd1962);
			send_sample(12'd2441);
			send_sample(12'd2442);
			wait_lines_done();
		end
	endtask

	task automatic test_random_samples();
		int r;
		begin
			for (int n = 0; n < RANDOM_SAMPLES; n++) begin
				r = $urandom_range(0, 9);
				if (r < 2)
					send_sample(12'($urandom_range(1895, 1920)));
				else
					send_sample(12'($urandom_range(0, 4095)));
			end
			wait_lines_done();
		end
	endtask

	task automatic test_backpressure();
		begin
			hold_request = 400;
			for (int n = 0; n < 5; n++)
				send_sample(12'($urandom_range(0, 4095)));
			wait_lines_done();
			for (int n = 0; n < 4; n++)
				send_sample(12'($urandom_range(0, 4095)));
			wait_lines_done();
		end
	endtask

	task automatic test_back_to_back();
		begin
			tx_idle_en = 1'b0;
			rx_idle_en = 1'b0;
			for (int n = 0; n < 20; n++)
				send_sample(12'($urandom_range(0, 4095)));
			wait_lines_done();
			tx_idle_en = 1'b1;
			rx_idle_en = 1'b1;
		end
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle_en && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		line_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_chars_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected char: expected none actual char=%h last=%b",
					$time, m_tdata, m_tlast);
			end else begin
				want = line_chars_q.pop_front();
				if (m_tdata !== want.ch) begin
					error_count++;
					$display("%0t: char mismatch: expected %h actual %h",
						$time, want.ch, m_tdata);
				end
				if (m_tlast !== want.last) begin
					error_count++;
					$display("%0t: last mismatch: expected %b actual %b",
						$time, want.last, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (LINE_LATENCY) @(posedge clk);
		test_extremes();
		test_sign_boundary();
		test_digit_count();
		test_backpressure();
		test_back_to_back();
		test_random_samples();
		if (line_chars_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d chars never arrived, next expected %h",
				$time, line_chars_q.size(), line_chars_q[0].ch);
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
hdl/adct_pkg.sv
hdl/adct_div.sv
hdl/adct_bcd.sv
hdl/adc_temperature_to_ascii_line.sv
tb/sv/tb.sv
